[src/fdct_pkg.sv]
// ----------------------------------------------------------------------------
// fdct_pkg
// Types, coefficient table and rounding codes for the 8x8 forward DCT.
// ----------------------------------------------------------------------------
`default_nettype none
package fdct_pkg;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_LOAD,
      ST_BFLY,
      ST_MAC,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_OUT
   } state_type;

   typedef enum logic [1:0] {
      RND_NONE,
      RND_2,
      RND_11,
      RND_15
   } rnd_type;

   typedef struct packed {
      logic mul_en;
      logic clr;
      logic acc_en;
   } mac_ctrl_type;

   localparam int unsigned DataW = 20;
   localparam int unsigned TermW = 21;
   localparam int unsigned CoefW = 16;
   localparam int unsigned ProdW = TermW + CoefW;
   localparam int unsigned AccW  = ProdW + 3;

   // row-pass weights; even outputs use t0..t3, odd outputs use t4..t7
   localparam logic signed [CoefW-1:0] COEF_TAB [8][4] = '{
      '{ 16'sd4,      16'sd4,      16'sd4,      16'sd4     },
      '{ 16'sd2260,   16'sd6437,   16'sd9633,   16'sd11363 },
      '{ 16'sd10703,  16'sd4433,  -16'sd4433,  -16'sd10703 },
      '{-16'sd6436,  -16'sd11362, -16'sd2259,   16'sd9633  },
      '{ 16'sd4,     -16'sd4,     -16'sd4,      16'sd4     },
      '{ 16'sd9633,   16'sd2261,  -16'sd11362,  16'sd6437  },
      '{ 16'sd4433,  -16'sd10704,  16'sd10704, -16'sd4433  },
      '{-16'sd11363,  16'sd9633,  -16'sd6436,   16'sd2260  }
   };

   function automatic logic signed [CoefW-1:0] coef_of(input logic col,
                                                      input logic [2:0] k,
                                                      input logic [1:0] i);
      logic signed [CoefW-1:0] c;
      c = COEF_TAB[k][i];
      if (col && (k[1:0] == 2'd0)) begin
         c = c >>> 2;
      end
      return c;
   endfunction

   function automatic rnd_type rnd_of(input logic col, input logic [2:0] k);
      rnd_type r;
      if (k[1:0] == 2'd0) begin
         r = col ? RND_2 : RND_NONE;
      end else begin
         r = col ? RND_15 : RND_11;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/forward_dct_8x8.sv]
// ----------------------------------------------------------------------------
// forward_dct_8x8
// Integer 8x8 forward DCT, row pass then column pass, on one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   req_sample takes 64 signed 8-bit samples of one block in row-major order,
//   one per transaction (req_valid high, req_stall low). Samples are taken one
//   per cycle while the block is filling.
//   After the 64th sample the block runs 16 line transforms (8 rows, 8 columns).
//   Each line takes 8 memory reads, a butterfly step and 8 outputs of 6
//   MAC-unit steps each. The shared multiplier and the block memory,
//   with its single read port, set the pace of the line transforms.
//   The 64 coefficients then leave on rsp_coefficient in row-major order,
//   rsp_last marks the 64th; each passes through a memory read, an output
//   load and the transaction, and the next is read only once the current
//   one is taken.
//   req_stall is high from the 64th sample until the last coefficient is taken.
//   rsp_stall holds the current coefficient; the block waits with it.
//   Synchronous reset empties the block and returns it to filling.
// ----------------------------------------------------------------------------
`default_nettype none
module forward_dct_8x8 (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [7:0]  req_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_coefficient,
   output logic                    rsp_last
);

   localparam int unsigned DW = fdct_pkg::DataW;
   localparam int unsigned TW = fdct_pkg::TermW;

   fdct_pkg::state_type state_ff, state_in;

   logic [5:0] fill_ff, fill_in;
   logic [3:0] line_ff, line_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [2:0] k_ff, k_in;
   logic [2:0] step_ff, step_in;
   logic [5:0] emit_ff, emit_in;

   logic signed [DW-1:0] mem [64];
   logic signed [DW-1:0] rdata_ff;
   logic                 we;
   logic [5:0]           waddr;
   logic signed [DW-1:0] wdata;
   logic [5:0]           raddr;

   logic signed [DW-1:0] x_ff [8];
   logic signed [TW-1:0] t_ff [8];

   logic signed [15:0]   coef_out_ff;
   logic                 last_out_ff;

   fdct_pkg::mac_ctrl_type               mac_ctrl;
   logic signed [TW-1:0]                 mac_op;
   logic signed [fdct_pkg::CoefW-1:0]    mac_coef;
   fdct_pkg::rnd_type                    mac_rnd;
   logic signed [DW-1:0]                 mac_result;
   logic signed [DW-1:0]                 sat_src;
   logic signed [15:0]                   sat_val;

   logic in_acc;
   logic out_acc;
   logic col;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;
   assign col     = line_ff[3];

   function automatic logic [5:0] line_addr(input logic [3:0] l, input logic [2:0] j);
      return l[3] ? {j, l[2:0]} : {l[2:0], j};
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fdct_pkg::ST_FILL: begin
            if (in_acc && (fill_ff == 6'd63)) begin
               state_in = fdct_pkg::ST_LOAD;
            end
         end
         fdct_pkg::ST_LOAD: begin
            if (cnt_ff == 4'd8) begin
               state_in = fdct_pkg::ST_BFLY;
            end
         end
         fdct_pkg::ST_BFLY: state_in = fdct_pkg::ST_MAC;
         fdct_pkg::ST_MAC: begin
            if ((step_ff == 3'd5) && (k_ff == 3'd7)) begin
               state_in = (line_ff == 4'd15) ? fdct_pkg::ST_EMIT_RD : fdct_pkg::ST_LOAD;
            end
         end
         fdct_pkg::ST_EMIT_RD:  state_in = fdct_pkg::ST_EMIT_LD;
         fdct_pkg::ST_EMIT_LD:  state_in = fdct_pkg::ST_EMIT_OUT;
         fdct_pkg::ST_EMIT_OUT: begin
            if (out_acc) begin
               state_in = (emit_ff == 6'd63) ? fdct_pkg::ST_FILL : fdct_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = fdct_pkg::ST_FILL;
      endcase
   end

   // outputs and counters
   always_comb begin
      fill_in  = fill_ff;
      line_in  = line_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      step_in  = step_ff;
      emit_in  = emit_ff;
      we       = 1'b0;
      waddr    = fill_ff;
      wdata    = DW'(req_sample);
      raddr    = emit_ff;
      mac_ctrl = '0;
      unique case (state_ff)
         fdct_pkg::ST_FILL: begin
            if (in_acc) begin
               we      = 1'b1;
               fill_in = fill_ff + 6'd1;
               line_in = '0;
               cnt_in  = '0;
            end
         end
         fdct_pkg::ST_LOAD: begin
            raddr  = line_addr(line_ff, cnt_ff[2:0]);
            cnt_in = cnt_ff + 4'd1;
         end
         fdct_pkg::ST_BFLY: begin
            k_in    = '0;
            step_in = '0;
         end
         fdct_pkg::ST_MAC: begin
            mac_ctrl.mul_en = (step_ff < 3'd4);
            mac_ctrl.clr    = (step_ff == 3'd0);
            mac_ctrl.acc_en = (step_ff != 3'd0) && (step_ff != 3'd5);
            if (step_ff == 3'd5) begin
               we      = 1'b1;
               waddr   = line_addr(line_ff, k_ff);
               wdata   = mac_result;
               step_in = '0;
               k_in    = k_ff + 3'd1;
               if (k_ff == 3'd7) begin
                  line_in = line_ff + 4'd1;
                  cnt_in  = '0;
                  emit_in = '0;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         fdct_pkg::ST_EMIT_RD: begin
         end
         fdct_pkg::ST_EMIT_LD: begin
         end
         fdct_pkg::ST_EMIT_OUT: begin
            if (out_acc) begin
               emit_in = emit_ff + 6'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign mac_op   = k_ff[0] ? t_ff[{1'b1, step_ff[1:0]}] : t_ff[{1'b0, step_ff[1:0]}];
   assign mac_coef = fdct_pkg::coef_of(col, k_ff, step_ff[1:0]);
   assign mac_rnd  = fdct_pkg::rnd_of(col, k_ff);

   fdct_mac u_mac (
      .clock  (clock),
      .op     (mac_op),
      .coef   (mac_coef),
      .ctrl   (mac_ctrl),
      .rnd    (mac_rnd),
      .result (mac_result)
   );

   assign sat_src = rdata_ff;
   always_comb begin
      if (sat_src > 20'sd32767) begin
         sat_val = 16'sd32767;
      end else if (sat_src < -20'sd32768) begin
         sat_val = -16'sd32768;
      end else begin
         sat_val = sat_src[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
      if ((state_ff == fdct_pkg::ST_LOAD) && (cnt_ff != 4'd0)) begin
         x_ff[3'(cnt_ff - 4'd1)] <= rdata_ff;
      end
      if (state_ff == fdct_pkg::ST_BFLY) begin
         for (int i = 0; i < 4; i++) begin
            t_ff[i]     <= TW'(x_ff[i]) + TW'(x_ff[7-i]);
            t_ff[4 + i] <= TW'(x_ff[3-i]) - TW'(x_ff[4+i]);
         end
      end
      if (state_ff == fdct_pkg::ST_EMIT_LD) begin
         coef_out_ff <= sat_val;
         last_out_ff <= (emit_ff == 6'd63);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdct_pkg::ST_FILL;
         fill_ff  <= '0;
         line_ff  <= '0;
         cnt_ff   <= '0;
         k_ff     <= '0;
         step_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         line_ff  <= line_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         step_ff  <= step_in;
         emit_ff  <= emit_in;
      end
   end

   assign req_stall       = (state_ff != fdct_pkg::ST_FILL);
   assign rsp_valid       = (state_ff == fdct_pkg::ST_EMIT_OUT);
   assign rsp_coefficient = coef_out_ff;
   assign rsp_last        = last_out_ff;

endmodule
`default_nettype wire

[src/fdct_mac.sv]
// ----------------------------------------------------------------------------
// fdct_mac
// Shared multiply-accumulate unit with selectable round-and-shift output.
// ----------------------------------------------------------------------------
`default_nettype none
module fdct_mac (
   input  wire logic                                   clock,
   input  wire logic signed [fdct_pkg::TermW-1:0]      op,
   input  wire logic signed [fdct_pkg::CoefW-1:0]      coef,
   input  wire fdct_pkg::mac_ctrl_type                 ctrl,
   input  wire fdct_pkg::rnd_type                      rnd,
   output logic signed [fdct_pkg::DataW-1:0]           result
);

   logic signed [fdct_pkg::ProdW-1:0] prod_ff;
   logic signed [fdct_pkg::AccW-1:0]  acc_ff;
   logic signed [fdct_pkg::AccW-1:0]  acc_in;
   logic signed [fdct_pkg::AccW-1:0]  shifted;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= op * coef;
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clr) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + fdct_pkg::AccW'(prod_ff);
      end
   end

   always_comb begin
      case (rnd)
         fdct_pkg::RND_2:  shifted = (acc_ff + 40'sd2) >>> 2;
         fdct_pkg::RND_11: shifted = (acc_ff + 40'sd1024) >>> 11;
         fdct_pkg::RND_15: shifted = (acc_ff + 40'sd16384) >>> 15;
         default:          shifted = acc_ff;
      endcase
   end

   assign result = shifted[fdct_pkg::DataW-1:0];

endmodule
`default_nettype wire

[sim/forward_dct_8x8_tb.sv]
// ----------------------------------------------------------------------------
// forward_dct_8x8_tb
// Self-checking bench for the 8x8 forward DCT: blocks of 64 samples are sent
// with random gaps, every coefficient is predicted and compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

class dct_scoreboard;
   logic signed [7:0]  pixels[64];
   int                 fill;
   logic signed [15:0] coef_q[$];
   logic               last_q[$];
   int                 errors;
   int                 coefs_seen;
   int                 blocks_done;

   function new();
      fill = 0;
      errors = 0;
      coefs_seen = 0;
      blocks_done = 0;
   endfunction

   static function longint rnd_shr(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   static function void line_dct(ref longint v[8], input bit col);
      longint t0, t1, t2, t3, t4, t5, t6, t7, e10, e11, e12, e13, m, a, b, c, d, s;
      int sh;
      sh = col ? 15 : 11;
      t0 = v[0] + v[7]; t7 = v[0] - v[7];
      t1 = v[1] + v[6]; t6 = v[1] - v[6];
      t2 = v[2] + v[5]; t5 = v[2] - v[5];
      t3 = v[3] + v[4]; t4 = v[3] - v[4];
      e10 = t0 + t3; e13 = t0 - t3; e11 = t1 + t2; e12 = t1 - t2;
      if (col) begin
         v[0] = rnd_shr(e10 + e11, 2);
         v[4] = rnd_shr(e10 - e11, 2);
      end else begin
         v[0] = (e10 + e11) * 4;
         v[4] = (e10 - e11) * 4;
      end
      m = (e12 + e13) * 4433;
      v[2] = rnd_shr(m + e13 * 6270, sh);
      v[6] = rnd_shr(m - e12 * 15137, sh);
      a = t4 + t7; b = t5 + t6; c = t4 + t6; d = t5 + t7;
      s = (c + d) * 9633;
      t4 = t4 * 2446; t5 = t5 * 16819; t6 = t6 * 25172; t7 = t7 * 12299;
      a = a * -7373; b = b * -20995;
      c = c * -16069 + s;
      d = d * -3196 + s;
      v[7] = rnd_shr(t4 + a + c, sh);
      v[5] = rnd_shr(t5 + b + d, sh);
      v[3] = rnd_shr(t6 + b + c, sh);
      v[1] = rnd_shr(t7 + a + d, sh);
   endfunction

   function void note_sample(logic signed [7:0] smp);
      longint w[64];
      longint ln[8];
      pixels[fill] = smp;
      fill = (fill + 1) % 64;
      if (fill != 0) return;
      foreach (w[k]) w[k] = pixels[k];
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++) ln[c] = w[r*8+c];
         line_dct(ln, 0);
         for (int c = 0; c < 8; c++) w[r*8+c] = ln[c];
      end
      for (int c = 0; c < 8; c++) begin
         for (int r = 0; r < 8; r++) ln[r] = w[r*8+c];
         line_dct(ln, 1);
         for (int r = 0; r < 8; r++) w[r*8+c] = ln[r];
      end
      for (int k = 0; k < 64; k++) begin
         if (w[k] > 32767) w[k] = 32767;
         if (w[k] < -32768) w[k] = -32768;
         coef_q.push_back(16'(w[k]));
         last_q.push_back(k == 63);
      end
   endfunction

   task report(string what);
      errors++;
      $display("error: %s", what);
   endtask

   task check_coef(logic signed [15:0] coef, logic lst);
      logic signed [15:0] want_c;
      logic want_l;
      coefs_seen++;
      if (coef_q.size() == 0) begin
         report($sformatf("unexpected coefficient %0d", coef));
         return;
      end
      want_c = coef_q.pop_front();
      want_l = last_q.pop_front();
      if (want_l) blocks_done++;
      if (coef !== want_c)
         report($sformatf("coef #%0d got %0d want %0d", coefs_seen, coef, want_c));
      if (lst !== want_l)
         report($sformatf("last #%0d got %b want %b", coefs_seen, lst, want_l));
   endtask
endclass

module forward_dct_8x8_tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [7:0]  req_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_coefficient;
   logic               rsp_last;

   dct_scoreboard sb = new();
   int  cycle_count = 0;
   bit  rsp_free_run = 0;
   logic signed [7:0] plan[$];

   localparam int CycleLimit = 400000;

   forward_dct_8x8 u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("forward_dct_8x8: mismatch");
         $finish;
      end
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_coef(rsp_coefficient, rsp_last);
   end

   always @(posedge clock) begin
      if (rsp_free_run || $urandom_range(99) < 60) rsp_stall <= 1'b0;
      else if ($urandom_range(99) < 95) rsp_stall <= ($urandom_range(3) == 0);
      else rsp_stall <= 1'b1;
   end

   task automatic send_sample(logic signed [7:0] smp);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      sb.note_sample(smp);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.coef_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: checkerboard of both extremes
      for (int k = 0; k < 64; k++) plan.push_back(8'(((k / 8 + k) % 2) ? 127 : -128));
      foreach (plan[i]) send_sample(plan[i]);
      wait_drained();
      plan.delete();
      for (int b = 0; b < 2; b++)
         for (int k = 0; k < 64; k++)
            plan.push_back(b == 0 ? 8'($urandom_range(3) * 85 - 128)
                                  : 8'($urandom_range(255)));
      foreach (plan[i]) send_sample(plan[i]);
      req_valid <= 1'b0;
      wait_drained();
      rsp_free_run = 1;
      repeat (1200) @(posedge clock);
      $display("sent %0d blocks of samples (checkerboard, coarse levels, random)",
               sb.blocks_done);
      $display("checked %0d coefficients with random stalls on both sides", sb.coefs_seen);
      if (sb.errors == 0 && sb.coef_q.size() == 0) begin
         $display("forward_dct_8x8: match");
      end else begin
         $display("forward_dct_8x8: mismatch");
      end
      $finish;
   end
endmodule

`default_nettype wire

[forward_dct_8x8.f]
src/fdct_pkg.sv
src/fdct_mac.sv
src/forward_dct_8x8.sv
sim/forward_dct_8x8_tb.sv
